// ----- sv/lcws_pkg.sv -----
package lcws_pkg;

  localparam int unsigned MAX_LAYERS_DEF = 16;

  // Chunks per sequence; must stay a power of two (chunk length is a shift)
  localparam int unsigned CHUNK_TARGET = 16;
  localparam int unsigned CHUNK_SHIFT  = $clog2(CHUNK_TARGET);

  // Per-layer progress in chunks, 0 .. CHUNK_TARGET
  localparam int unsigned CHUNK_W  = $clog2(CHUNK_TARGET + 1);
  localparam int unsigned SEQ_W    = 16;
  localparam int unsigned LEN_W    = 13;
  localparam int unsigned START_W  = CHUNK_W + LEN_W;
  localparam int unsigned NL_W     = 5;
  localparam int unsigned NS_W     = 5;
  localparam int unsigned STREAM_W = 4;
  localparam int unsigned MAX_STREAMS = 16;

  localparam int unsigned CFG_ADDR_W = 2;
  localparam int unsigned CFG_DATA_W = 16;

  localparam int unsigned IN_TDATA_W  = 8;
  localparam int unsigned OUT_TDATA_W = 48;
  localparam int unsigned OUT_TUSER_W = 2;
  localparam int unsigned USER_GRANT  = 0;
  localparam int unsigned USER_DONE   = 1;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_NUM_LAYERS  = 2'd0,
    CFG_SEQ_LEN     = 2'd1,
    CFG_NUM_STREAMS = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic rd;
    logic wr;
    logic clr;
  } store_ctrl_t;

endpackage

// ----- sv/layer_chunk_wavefront_scheduler.sv -----
// Wavefront chunk scheduler for a multi-layer sequence job.
// Config port: cfg_we_i writes cfg_wdata_i into register cfg_addr_i
// (0 num_layers, 1 seq_len, 2 num_streams); write only while idle.
// Input stream: one item requests one scheduling round; tdata[0] set
// clears all layer progress first (start of a new job).
// Output stream: one item per granted chunk, tlast on the last item of
// the round. A round with no grant gives one item with tuser all_done set.
// A round reads one layer per cycle, while the output register is not stalled,
// through the single read port of the progress store, and each layer then
// passes through the read, multiply and decide stages.
// s_axis_tready is high only between rounds.
// A grant is held back until the next grant or the round end reaches the
// decide stage, so tlast can be marked on the last one.
// A stalled receiver freezes the whole pipeline; the output register
// holds its item until taken, and the next round may be accepted while
// the final item of the previous one still waits.
// Reset sets num_layers 1, seq_len 1, num_streams 2 and clears progress
// at once (valid bits), so the block is ready on the first cycle.
module layer_chunk_wavefront_scheduler #(
  parameter int unsigned MAX_LAYERS = lcws_pkg::MAX_LAYERS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [lcws_pkg::CFG_ADDR_W-1:0]   cfg_addr_i,
  input  logic [lcws_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // [0] new_job, [7:1] zero
  input  logic [lcws_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // [3:0] layer_index, [7:4] chunk_index, [23:8] time_offset,
  // [36:24] chunk_length, [40:37] stream_index, [41] wait_prev_chunk,
  // [42] wait_prev_layer, [47:43] zero
  output logic [lcws_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
  // [0] grant_valid, [1] all_done
  output logic [lcws_pkg::OUT_TUSER_W-1:0]  m_axis_tuser,
  output logic                              m_axis_tlast
);

  localparam int unsigned LW = (MAX_LAYERS > 1) ? $clog2(MAX_LAYERS) : 1;
  localparam int unsigned CW = $clog2(MAX_LAYERS + 1);
  localparam int unsigned SW = lcws_pkg::START_W;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_ISSUE = 3'b010,
    ST_DRAIN = 3'b100
  } state_e;

  // Configuration
  logic [lcws_pkg::NL_W-1:0]  num_layers_q;
  logic [lcws_pkg::SEQ_W-1:0] seq_len_q;
  logic [lcws_pkg::NS_W-1:0]  num_streams_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_layers_q  <= lcws_pkg::NL_W'(1);
      seq_len_q     <= lcws_pkg::SEQ_W'(1);
      num_streams_q <= lcws_pkg::NS_W'(2);
    end else if (cfg_we_i) begin
      case (lcws_pkg::cfg_idx_e'(cfg_addr_i))
        lcws_pkg::CFG_NUM_LAYERS:  num_layers_q  <= cfg_wdata_i[lcws_pkg::NL_W-1:0];
        lcws_pkg::CFG_SEQ_LEN:     seq_len_q     <= cfg_wdata_i[lcws_pkg::SEQ_W-1:0];
        lcws_pkg::CFG_NUM_STREAMS: num_streams_q <= cfg_wdata_i[lcws_pkg::NS_W-1:0];
        default: ;
      endcase
    end
  end

  // Derived round constants
  logic [lcws_pkg::SEQ_W:0]       seq_round;
  logic [lcws_pkg::LEN_W-1:0]     len;
  logic [CW-1:0]                  layers;
  logic [lcws_pkg::NS_W-1:0]      streams;
  logic                           multi;
  logic [lcws_pkg::STREAM_W-1:0]  first;
  logic [lcws_pkg::STREAM_W-1:0]  round_n;

  assign seq_round = {1'b0, seq_len_q} + (lcws_pkg::SEQ_W + 1)'(lcws_pkg::CHUNK_TARGET - 1);
  assign len       = lcws_pkg::LEN_W'(seq_round >> lcws_pkg::CHUNK_SHIFT);
  assign layers    = ({3'b000, num_layers_q} > 8'(MAX_LAYERS)) ? CW'(MAX_LAYERS)
                                                             : CW'(num_layers_q);
  assign streams   = (num_streams_q > lcws_pkg::NS_W'(lcws_pkg::MAX_STREAMS))
                     ? lcws_pkg::NS_W'(lcws_pkg::MAX_STREAMS) : num_streams_q;
  assign multi     = streams > lcws_pkg::NS_W'(1);
  assign first     = multi ? lcws_pkg::STREAM_W'(1) : '0;
  assign round_n   = multi ? lcws_pkg::STREAM_W'(streams - lcws_pkg::NS_W'(1))
                           : lcws_pkg::STREAM_W'(1);

  // Control
  state_e                        state_q, state_d;
  logic [CW-1:0]                 ra_q, ra_d;
  logic [lcws_pkg::STREAM_W-1:0] rr_q, rr_d, rr_next;
  logic                          accept, adv, issue, issue_end, issue_rd;

  // Pipeline stages
  logic                          a_vld_q, a_flush_q;
  logic [LW-1:0]                 a_layer_q;
  logic                          b_vld_q, b_flush_q;
  logic [LW-1:0]                 b_layer_q;
  logic [lcws_pkg::CHUNK_W-1:0]  b_chunk_q;
  logic [SW-1:0]                 b_start_q;
  logic [SW-1:0]                 prev_start_q;
  logic [lcws_pkg::CHUNK_W-1:0]  rd_chunk;

  // Held grant and output register
  logic                               hold_vld_q, hold_vld_d;
  logic [lcws_pkg::OUT_TDATA_W-1:0]   hold_data_q;
  logic                               m_valid_q, m_valid_d;
  logic [lcws_pkg::OUT_TDATA_W-1:0]   m_data_q;
  logic [lcws_pkg::OUT_TUSER_W-1:0]   m_user_q;
  logic                               m_last_q;

  // Decide stage
  logic                               c_do, in_range, dep_ok, grant, out_load;
  logic [SW:0]                        end_sum, end_cap;
  logic [lcws_pkg::OUT_TDATA_W-1:0]   grant_data;
  logic [lcws_pkg::STREAM_W-1:0]      stream;

  lcws_pkg::store_ctrl_t st_ctrl;

  assign adv           = !m_valid_q || m_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign issue         = (state_q == ST_ISSUE) && adv;
  assign issue_end     = issue && (ra_q == layers);
  assign issue_rd      = issue && (ra_q != layers);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (accept) state_d = ST_ISSUE;
      ST_ISSUE: if (issue_end) state_d = ST_DRAIN;
      ST_DRAIN: if (adv && b_vld_q && b_flush_q) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  assign ra_d = accept ? '0 : (issue_rd ? ra_q + CW'(1) : ra_q);

  assign rr_next = (rr_q + lcws_pkg::STREAM_W'(1) == round_n) ? '0
                                                              : rr_q + lcws_pkg::STREAM_W'(1);

  // Decide: committed progress of the layer below equals its progress at
  // round start, which is the start offset computed for it one step earlier.
  assign c_do     = adv && b_vld_q;
  assign in_range = b_start_q < SW'(seq_len_q);
  assign end_sum  = (SW + 1)'(b_start_q) + (SW + 1)'(len);
  assign end_cap  = (end_sum > (SW + 1)'(seq_len_q)) ? (SW + 1)'(seq_len_q) : end_sum;
  assign dep_ok   = (b_layer_q == '0) || ((SW + 1)'(prev_start_q) >= end_cap);
  assign grant    = b_vld_q && !b_flush_q && in_range && dep_ok;
  assign stream   = first + rr_q;

  assign grant_data = {5'b00000,
                       (b_layer_q != '0),
                       (b_chunk_q != '0),
                       stream,
                       len,
                       b_start_q[lcws_pkg::SEQ_W-1:0],
                       b_chunk_q[3:0],
                       4'(b_layer_q)};

  assign out_load   = c_do && (b_flush_q || (grant && hold_vld_q));
  assign m_valid_d  = out_load ? 1'b1 : (m_axis_tready ? 1'b0 : m_valid_q);
  assign hold_vld_d = (c_do && b_flush_q) ? 1'b0 : ((c_do && grant) ? 1'b1 : hold_vld_q);
  assign rr_d       = accept ? '0 : ((c_do && grant) ? rr_next : rr_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      ra_q       <= '0;
      rr_q       <= '0;
      a_vld_q    <= 1'b0;
      a_flush_q  <= 1'b0;
      b_vld_q    <= 1'b0;
      b_flush_q  <= 1'b0;
      hold_vld_q <= 1'b0;
      m_valid_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      ra_q       <= ra_d;
      rr_q       <= rr_d;
      hold_vld_q <= hold_vld_d;
      m_valid_q  <= m_valid_d;
      if (adv) begin
        a_vld_q   <= issue;
        a_flush_q <= issue_end;
        b_vld_q   <= a_vld_q;
        b_flush_q <= a_flush_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      a_layer_q <= ra_q[LW-1:0];
      b_layer_q <= a_layer_q;
      b_chunk_q <= rd_chunk;
      b_start_q <= SW'(rd_chunk) * SW'(len);
    end
    if (c_do && !b_flush_q) begin
      prev_start_q <= b_start_q;
    end
    if (c_do && grant) begin
      hold_data_q <= grant_data;
    end
    if (out_load) begin
      m_last_q <= b_flush_q;
      if (b_flush_q && !hold_vld_q) begin
        m_data_q <= '0;
        m_user_q <= lcws_pkg::OUT_TUSER_W'(1 << lcws_pkg::USER_DONE);
      end else begin
        m_data_q <= hold_data_q;
        m_user_q <= lcws_pkg::OUT_TUSER_W'(1 << lcws_pkg::USER_GRANT);
      end
    end
  end

  // Writes land on layers already read this round; the next round reads
  // only after the pipeline has drained, so no forwarding is needed.
  assign st_ctrl.rd  = issue_rd;
  assign st_ctrl.wr  = c_do && grant;
  assign st_ctrl.clr = accept && s_axis_tdata[0];

  lcws_store #(
    .DEPTH (MAX_LAYERS),
    .AW    (LW)
  ) u_store (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (st_ctrl),
    .raddr_i (ra_q[LW-1:0]),
    .waddr_i (b_layer_q),
    .wdata_i (b_chunk_q + lcws_pkg::CHUNK_W'(1)),
    .rdata_o (rd_chunk)
  );

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;
  assign m_axis_tlast  = m_last_q;

  a_accept_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> (!a_vld_q && !b_vld_q && !hold_vld_q))
    else $error("round accepted with pipeline not empty");

  a_store_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_ctrl.rd && st_ctrl.wr) |-> (ra_q[LW-1:0] != b_layer_q))
    else $error("store read and write hit the same layer");

  a_rr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> (rr_q < round_n))
    else $error("stream counter out of range");

  a_flush_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && b_vld_q && b_flush_q) |=> (m_axis_tvalid && m_axis_tlast))
    else $error("round end did not produce a last item");

endmodule

// ----- sv/lcws_store.sv -----
module lcws_store #(
  parameter int unsigned DEPTH = lcws_pkg::MAX_LAYERS_DEF,
  parameter int unsigned AW    = 4
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  lcws_pkg::store_ctrl_t       ctrl_i,
  input  logic [AW-1:0]               raddr_i,
  input  logic [AW-1:0]               waddr_i,
  input  logic [lcws_pkg::CHUNK_W-1:0] wdata_i,
  output logic [lcws_pkg::CHUNK_W-1:0] rdata_o
);

  logic [lcws_pkg::CHUNK_W-1:0] mem_q [DEPTH];
  logic [lcws_pkg::CHUNK_W-1:0] rdata_q;
  logic [DEPTH-1:0]             vld_q;
  logic                         rvld_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.wr) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (ctrl_i.rd) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  // An entry not written since reset or the last job start reads as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      rvld_q <= 1'b0;
    end else begin
      if (ctrl_i.clr) begin
        vld_q <= '0;
      end else if (ctrl_i.wr) begin
        vld_q[waddr_i] <= 1'b1;
      end
      if (ctrl_i.rd) begin
        rvld_q <= vld_q[raddr_i];
      end
    end
  end

  assign rdata_o = rvld_q ? rdata_q : '0;

endmodule

// ----- sim/layer_chunk_wavefront_scheduler_test.sv -----
`timescale 1ns / 100ps

module layer_chunk_wavefront_scheduler_test;

  typedef struct packed {
    logic        grant;
    logic [3:0]  layer;
    logic [3:0]  chunk;
    logic [15:0] offset;
    logic [12:0] length;
    logic [3:0]  stream;
    logic        wait_chunk;
    logic        wait_layer;
    logic        done;
    logic        last;
  } dispatch_t;

  logic                                clk_i;
  logic                                rst_ni;
  logic                                cfg_we_i;
  logic [lcws_pkg::CFG_ADDR_W-1:0]     cfg_addr_i;
  logic [lcws_pkg::CFG_DATA_W-1:0]     cfg_wdata_i;
  logic                                s_axis_tvalid;
  logic                                s_axis_tready;
  // [0] new_job, [7:1] zero
  logic [lcws_pkg::IN_TDATA_W-1:0]     s_axis_tdata;
  logic                                m_axis_tvalid;
  logic                                m_axis_tready;
  // [3:0] layer_index, [7:4] chunk_index, [23:8] time_offset,
  // [36:24] chunk_length, [40:37] stream_index, [41] wait_prev_chunk,
  // [42] wait_prev_layer, [47:43] zero
  logic [lcws_pkg::OUT_TDATA_W-1:0]    m_axis_tdata;
  // [0] grant_valid, [1] all_done
  logic [lcws_pkg::OUT_TUSER_W-1:0]    m_axis_tuser;
  logic                                m_axis_tlast;

  layer_chunk_wavefront_scheduler u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  // Scheduler shadow: configuration and per-layer progress in chunks
  logic [4:0]  sh_layers;
  logic [15:0] sh_seq_len;
  logic [4:0]  sh_streams;
  logic [4:0]  committed_chunks_q [16];
  logic [4:0]  pending_chunks_q [16];
  bit          job_finished;

  dispatch_t   dispatch_q [$];

  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned rounds_sent;
  int unsigned dispatches_checked;
  int unsigned reg_writes;
  int unsigned errors_seen;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("layer_chunk_wavefront_scheduler_test: FAIL");
    $finish;
  end

  // Work out the dispatches of one round and queue them
  function automatic void schedule_round(input logic new_job);
    int unsigned len;
    int unsigned layers;
    int unsigned streams;
    int unsigned first;
    int unsigned rr_mod;
    int unsigned rr;
    int unsigned chunk;
    int unsigned start;
    int unsigned stop;
    bit          ok;
    dispatch_t   r;
    dispatch_t   round_q [$];
    len     = (32'(sh_seq_len) + 32'd15) / 32'd16;
    layers  = (sh_layers > 5'd16) ? 32'd16 : 32'(sh_layers);
    streams = (sh_streams > 5'd16) ? 32'd16 : 32'(sh_streams);
    first   = (streams > 1) ? 1 : 0;
    rr_mod  = (streams > 1) ? streams - 1 : 1;
    rr      = 0;
    for (int l = 0; l < 16; l++) begin
      if (new_job) begin
        pending_chunks_q[l] = '0;
      end
      committed_chunks_q[l] = pending_chunks_q[l];
    end
    for (int unsigned l = 0; l < layers; l++) begin
      chunk = pending_chunks_q[l];
      start = chunk * len;
      if (start >= sh_seq_len) begin
        ok = 1'b0;
      end else if (l == 0) begin
        ok = 1'b1;
      end else begin
        // the layer below must have committed up to this chunk's end
        stop = start + len;
        if (stop > sh_seq_len) stop = sh_seq_len;
        ok = (committed_chunks_q[l-1] * len) >= stop;
      end
      if (ok) begin
        r            = '0;
        r.grant      = 1'b1;
        r.layer      = l[3:0];
        r.chunk      = chunk[3:0];
        r.offset     = start[15:0];
        r.length     = len[12:0];
        r.stream     = 4'(first + rr);
        r.wait_chunk = (chunk > 0);
        r.wait_layer = (l > 0);
        round_q.push_back(r);
        pending_chunks_q[l] = 5'(chunk + 1);
        rr = (rr + 1) % rr_mod;
      end
    end
    job_finished = (round_q.size() == 0);
    if (job_finished) begin
      r      = '0;
      r.done = 1'b1;
      round_q.push_back(r);
    end
    round_q[round_q.size()-1].last = 1'b1;
    foreach (round_q[i]) dispatch_q.push_back(round_q[i]);
  endfunction

  task automatic request_round(input logic new_job);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    schedule_round(new_job);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {7'b0, new_job};
    do @(posedge clk_i); while (!s_axis_tready);
    rounds_sent++;
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (dispatch_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic set_config(input logic [4:0] layers, input logic [15:0] seq_len,
                            input logic [4:0] streams);
    wait_idle();
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= lcws_pkg::CFG_NUM_LAYERS;
    cfg_wdata_i <= {11'b0, layers};
    @(posedge clk_i);
    cfg_addr_i  <= lcws_pkg::CFG_SEQ_LEN;
    cfg_wdata_i <= seq_len;
    @(posedge clk_i);
    cfg_addr_i  <= lcws_pkg::CFG_NUM_STREAMS;
    cfg_wdata_i <= {11'b0, streams};
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    sh_layers  = layers;
    sh_seq_len = seq_len;
    sh_streams = streams;
    reg_writes += 3;
  endtask

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      errors_seen++;
      $display("%0t: %s mismatch: expected %0h, got %0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk_i) begin : check_dispatch
    dispatch_t got;
    dispatch_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.grant      = m_axis_tuser[lcws_pkg::USER_GRANT];
      got.done       = m_axis_tuser[lcws_pkg::USER_DONE];
      got.layer      = m_axis_tdata[3:0];
      got.chunk      = m_axis_tdata[7:4];
      got.offset     = m_axis_tdata[23:8];
      got.length     = m_axis_tdata[36:24];
      got.stream     = m_axis_tdata[40:37];
      got.wait_chunk = m_axis_tdata[41];
      got.wait_layer = m_axis_tdata[42];
      got.last       = m_axis_tlast;
      if (dispatch_q.size() == 0) begin
        errors_seen++;
        $display("%0t: unexpected item: expected none, got tdata %0h tuser %0h",
                 $time, m_axis_tdata, m_axis_tuser);
      end else begin
        want = dispatch_q.pop_front();
        check_field("grant_valid", want.grant, got.grant);
        check_field("layer_index", want.layer, got.layer);
        check_field("chunk_index", want.chunk, got.chunk);
        check_field("time_offset", want.offset, got.offset);
        check_field("chunk_length", want.length, got.length);
        check_field("stream_index", want.stream, got.stream);
        check_field("wait_prev_chunk", want.wait_chunk, got.wait_chunk);
        check_field("wait_prev_layer", want.wait_layer, got.wait_layer);
        check_field("all_done", want.done, got.done);
        check_field("last_of_round", want.last, got.last);
        dispatches_checked++;
      end
    end
  end

  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Reset values: one layer, one time step, two streams
  task automatic test_reset_defaults();
    request_round(1'b1);
    request_round(1'b0);
  endtask

  task automatic test_extremes();
    set_config(5'd16, 16'hFFFF, 5'd16);
    request_round(1'b1);
    repeat (3) request_round(1'b0);
  endtask

  // Zero and oversized layer/stream counts, zero length, single stream
  task automatic test_layer_stream_limits();
    set_config(5'd0, 16'd100, 5'd0);
    request_round(1'b1);
    set_config(5'd20, 16'd0, 5'd20);
    request_round(1'b1);
    set_config(5'd31, 16'd16, 5'd31);
    request_round(1'b1);
    repeat (4) request_round(1'b0);
    set_config(5'd3, 16'd5, 5'd1);
    request_round(1'b1);
    repeat (2) request_round(1'b0);
  endtask

  // Capped last chunk, then a new length in the middle of the job
  task automatic test_odd_lengths_and_reconfig();
    set_config(5'd3, 16'd17, 5'd3);
    request_round(1'b1);
    repeat (3) request_round(1'b0);
    set_config(5'd3, 16'd40, 5'd5);
    repeat (4) request_round(1'b0);
  endtask

  task automatic test_random_jobs(input int unsigned send_pct, input int unsigned recv_pct,
                                  input int unsigned quota);
    int unsigned first_round;
    logic [4:0]  layers;
    logic [15:0] seq_len;
    logic [4:0]  streams;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    first_round   = rounds_sent;
    while (rounds_sent - first_round < quota) begin
      case ($urandom_range(9))
        0:       layers = 5'd0;
        1:       layers = 5'd16;
        2:       layers = 5'($urandom_range(31, 17));
        default: layers = 5'($urandom_range(6, 1));
      endcase
      case ($urandom_range(9))
        0:       seq_len = 16'd0;
        1:       seq_len = 16'hFFFF;
        2, 3:    seq_len = 16'($urandom_range(40, 1));
        default: seq_len = 16'($urandom_range(65535, 1));
      endcase
      case ($urandom_range(9))
        0:       streams = 5'd0;
        1:       streams = 5'($urandom_range(31, 17));
        default: streams = 5'($urandom_range(16, 1));
      endcase
      set_config(layers, seq_len, streams);
      // most jobs start clean; the rest carry progress across the new setting
      request_round($urandom_range(99) < 80);
      while (!job_finished && rounds_sent - first_round < quota) begin
        request_round($urandom_range(99) < 5);
      end
      if ($urandom_range(99) < 30) request_round(1'b0);
    end
  endtask

  initial begin
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_addr_i    = lcws_pkg::CFG_NUM_LAYERS;
    cfg_wdata_i   = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    sh_layers     = 5'd1;
    sh_seq_len    = 16'd1;
    sh_streams    = 5'd2;
    for (int l = 0; l < 16; l++) begin
      committed_chunks_q[l] = '0;
      pending_chunks_q[l]   = '0;
    end
    job_finished       = 1'b0;
    send_idle_pct      = 26;
    recv_idle_pct      = 69;
    rounds_sent        = 0;
    dispatches_checked = 0;
    reg_writes         = 0;
    errors_seen        = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_defaults();
    test_extremes();
    test_layer_stream_limits();
    test_odd_lengths_and_reconfig();
    test_random_jobs(26, 69, 100);
    test_random_jobs(69, 26, 100);
    test_random_jobs(0, 0, 100);

    wait_idle();
    repeat (40) @(posedge clk_i);
    $display("covered %0d scheduling rounds and %0d dispatch items checked",
             rounds_sent, dispatches_checked);
    $display("over %0d register writes, including zero, oversized and extreme settings",
             reg_writes);
    if (errors_seen == 0) begin
      $display("layer_chunk_wavefront_scheduler_test: PASS");
    end else begin
      $display("layer_chunk_wavefront_scheduler_test: FAIL");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
sv/lcws_pkg.sv
sv/lcws_store.sv
sv/layer_chunk_wavefront_scheduler.sv
sim/layer_chunk_wavefront_scheduler_test.sv
